FILE: design/sos_pkg.sv
// shared types, constants and command codes for the odd-only segment sieve
package sos_pkg;

  localparam int SegSlots   = 4096;
  localparam int BasePrimes = 1024;
  localparam int MapWords   = (SegSlots + 63) / 64;
  localparam int SlotW      = $clog2(SegSlots);
  localparam int WordW      = $clog2(MapWords);
  localparam int PrimeAw    = $clog2(BasePrimes);
  localparam int CountW     = PrimeAw + 1;
  localparam int BaseW      = 40;
  localparam int PrimeW     = 20;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_SEGMENT = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [PrimeW-1:0] base_prime;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]       word_index;
    logic [63:0]      composite_bits;
    logic [BaseW-1:0] segment_low;
    logic             status;
    logic             last;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LMUL, ST_LDIV, ST_LFIN, ST_CLEAR, ST_RD, ST_WAIT,
    ST_CROSS, ST_MARK, ST_WB, ST_EMIT_RD, ST_EMIT, ST_SINGLE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic start_load;
    logic div_step;
    logic load_commit;
    logic seg_begin;
    logic clear_word;
    logic read_prime;
    logic cross_read;
    logic cross_step;
    logic write_back;
    logic emit_read;
    logic out_load_map;
    logic out_load_single;
    logic restart;
  } ctl_cmd_t;

  // status back to controller
  typedef struct packed {
    logic load_skip;   // invalid prime or table full
    logic div_done;
    logic clear_done;
    logic primes_done;
    logic cross_done;
    logic words_done;
  } ctl_stat_t;

endpackage

FILE: design/segmented_odd_prime_sieve_unit.sv
// top level of the odd-only segmented sieve; one item at a time, in_stall high while busy
// load: the 40-step bit-serial remainder of the base by the prime sets the stored offset,
//   then one result beat follows
// segment: clears the bitmap, per stored prime reads it, crosses off its multiples and
//   writes the offset back, then emits one beat per bitmap word; restart and unused give one beat
// any result beat held by out_stall holds the controller; synchronous active-high rst
//   empties the table and sets the start and the base to 3
module segmented_odd_prime_sieve_unit import sos_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [BaseW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  logic      in_take;

  // sequencer
  sos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_data.cmd),
    .in_take   (in_take),
    .stat      (stat),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // stores, divider and the output beat register
  sos_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_item  (in_data),
    .in_take  (in_take),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_data)
  );

endmodule

FILE: design/sos_datapath.sv
// datapath: prime store, offset store, segment bitmap, divider and output register
module sos_datapath import sos_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [BaseW-1:0]     cfg_data,
  input  in_beat_t             in_item,
  input  logic                 in_take,
  input  ctl_cmd_t             cmd,
  output ctl_stat_t            stat,
  output out_beat_t            out_item
);

  logic [PrimeW-1:0] prime_mem [BasePrimes];
  logic [BaseW-1:0]  offs_mem  [BasePrimes];
  logic [63:0]       map_mem   [MapWords];

  logic [BaseW-1:0]  start_reg;
  logic [BaseW-1:0]  segment_base;
  logic [CountW-1:0] prime_count;
  logic              first_done;

  logic [1:0]        cur_cmd;
  logic [PrimeW-1:0] cur_p;
  logic              status;

  // load arithmetic
  logic [BaseW-1:0]  nb;
  logic [BaseW-1:0]  sq;
  logic [PrimeW:0]   rem;
  logic [5:0]        div_cnt;

  // segment walk
  logic [CountW-1:0] idx;
  logic [PrimeW-1:0] rd_p;
  logic [BaseW-1:0]  rd_off;
  logic [BaseW-1:0]  off;
  logic              off_load;
  logic [WordW:0]    widx;
  logic [63:0]       rd_word;

  logic [BaseW-1:0]  eff_start;
  logic [BaseW-1:0]  next_base;
  logic [PrimeW:0]   rem_sh;
  logic [BaseW-1:0]  first_m;
  logic [BaseW-1:0]  first_lo;

  assign eff_start = cfg_data | BaseW'(1);
  assign next_base = segment_base + BaseW'(2 * SegSlots);
  assign rem_sh    = {rem[PrimeW-1:0], nb[6'(BaseW - 1) - div_cnt]};

  always_comb begin
    first_lo = (rem == '0) ? nb : nb + BaseW'(cur_p) - BaseW'(rem);
    if (!first_lo[0]) first_lo = first_lo + BaseW'(cur_p);
    first_m = (sq < nb) ? first_lo : sq;
  end

  assign stat.load_skip  = (cur_p < PrimeW'(3)) || !cur_p[0] ||
                           (prime_count >= CountW'(BasePrimes));
  assign stat.div_done   = (div_cnt == 6'(BaseW - 1));
  assign stat.clear_done = (widx == (WordW+1)'(MapWords - 1));
  assign stat.primes_done = (idx >= prime_count);
  assign stat.cross_done = (off >= BaseW'(SegSlots));
  assign stat.words_done = (widx == (WordW+1)'(MapWords - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg    <= BaseW'(3);
      segment_base <= BaseW'(3);
      prime_count  <= '0;
      first_done   <= 1'b0;
    end else if (cfg_we) begin
      start_reg    <= cfg_data;
      segment_base <= eff_start;
      first_done   <= 1'b0;
    end else begin
      if (cmd.restart) begin
        prime_count  <= '0;
        segment_base <= start_reg | BaseW'(1);
        first_done   <= 1'b0;
      end
      if (cmd.seg_begin) begin
        if (first_done) segment_base <= next_base;
        first_done <= 1'b1;
      end
      if (cmd.load_commit) prime_count <= prime_count + CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cur_cmd <= in_item.cmd;
      cur_p   <= in_item.base_prime;
      status  <= 1'b0;
      widx    <= '0;
    end
    if (cmd.start_load) begin
      nb      <= first_done ? next_base : segment_base;
      sq      <= BaseW'(cur_p) * BaseW'(cur_p);
      rem     <= '0;
      div_cnt <= '0;
      status  <= (cur_p >= PrimeW'(3)) && cur_p[0] &&
                 (prime_count >= CountW'(BasePrimes));
    end
    if (cmd.div_step) begin
      // restoring division, one bit a cycle
      if (rem_sh >= {1'b0, cur_p}) rem <= rem_sh - {1'b0, cur_p};
      else rem <= rem_sh;
      div_cnt <= div_cnt + 6'd1;
    end
    if (cmd.load_commit) begin
      prime_mem[prime_count[PrimeAw-1:0]] <= cur_p;
      offs_mem[prime_count[PrimeAw-1:0]]  <= (first_m - nb) >> 1;
    end
    if (cmd.seg_begin) idx <= '0;
    if (cmd.clear_word) begin
      map_mem[widx[WordW-1:0]] <= '0;
      widx <= stat.clear_done ? '0 : widx + (WordW+1)'(1);
    end
    if (cmd.read_prime) begin
      rd_p   <= prime_mem[idx[PrimeAw-1:0]];
      rd_off <= offs_mem[idx[PrimeAw-1:0]];
    end
    // offset register loads from the store the cycle after the read
    if (off_load) off <= rd_off;
    // bitmap word read, then written back with the slot marked
    if (cmd.emit_read) rd_word <= map_mem[widx[WordW-1:0]];
    else if (cmd.cross_read) rd_word <= map_mem[off[SlotW-1:6]];
    if (cmd.cross_step) begin
      map_mem[off[SlotW-1:6]] <= rd_word | (64'd1 << off[5:0]);
      off <= off + BaseW'(rd_p);
    end
    if (cmd.write_back) begin
      offs_mem[idx[PrimeAw-1:0]] <= off - BaseW'(SegSlots);
      idx <= idx + CountW'(1);
    end
    if (cmd.out_load_map) begin
      out_item.word_index     <= 6'(widx);
      out_item.composite_bits <= rd_word;
      out_item.segment_low    <= segment_base;
      out_item.status         <= 1'b0;
      out_item.last           <= stat.words_done;
      widx <= widx + (WordW+1)'(1);
    end
    if (cmd.out_load_single) begin
      out_item.word_index     <= '0;
      out_item.composite_bits <= '0;
      out_item.segment_low    <= (cur_cmd == CMD_RESTART) ? (start_reg | BaseW'(1))
                                                          : segment_base;
      out_item.status         <= (cur_cmd == CMD_LOAD) ? status : 1'b0;
      out_item.last           <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) off_load <= 1'b0;
    else off_load <= cmd.read_prime;
  end

endmodule

FILE: design/sos_ctrl.sv
// controller state machine sequencing load, segment and restart work
module sos_ctrl import sos_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  output logic       in_take,
  input  ctl_stat_t  stat,
  output ctl_cmd_t   cmd,
  output logic       out_valid,
  input  logic       out_stall
);

  state_t state, state_next;
  logic [1:0] cur_cmd;
  logic out_full, out_full_next;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) cur_cmd <= in_cmd;
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    out_full_next = out_full && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (in_cmd)
            CMD_LOAD:    state_next = ST_LMUL;
            CMD_SEGMENT: state_next = ST_CLEAR;
            default:     state_next = ST_SINGLE;
          endcase
        end
      end
      ST_LMUL: begin
        cmd.start_load = 1'b1;
        state_next = ST_LDIV;
      end
      ST_LDIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = ST_LFIN;
      end
      ST_LFIN: begin
        if (!stat.load_skip) cmd.load_commit = 1'b1;
        state_next = ST_SINGLE;
      end
      ST_SINGLE: begin
        if (!out_full_next) begin
          cmd.out_load_single = 1'b1;
          if (cur_cmd == CMD_RESTART) cmd.restart = 1'b1;
          out_full_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        // widx was zeroed when the beat was taken; base advances on the last word, but not for the first segment
        cmd.clear_word = 1'b1;
        if (stat.clear_done) begin
          cmd.seg_begin = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        if (stat.primes_done) state_next = ST_EMIT_RD;
        else begin
          cmd.read_prime = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT:  state_next = ST_CROSS;
      ST_CROSS: begin
        if (stat.cross_done) state_next = ST_WB;
        else begin
          cmd.cross_read = 1'b1;
          state_next = ST_MARK;
        end
      end
      ST_MARK: begin
        cmd.cross_step = 1'b1;
        state_next = ST_CROSS;
      end
      ST_WB: begin
        cmd.write_back = 1'b1;
        state_next = ST_RD;
      end
      ST_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_full_next) begin
          cmd.out_load_map = 1'b1;
          out_full_next = 1'b1;
          state_next = stat.words_done ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the odd-only segmented sieve unit
`timescale 1ns / 1ps

module tb_top import sos_pkg::*; ();

  localparam int SLOTS = SegSlots;
  localparam int WORDS = MapWords;
  localparam int TABLE_DEPTH = BasePrimes;
  localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [BaseW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;

  segmented_odd_prime_sieve_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow state of the sieve
  longint unsigned sh_start;
  longint unsigned sh_base;
  int unsigned sh_count;
  bit sh_first_done;
  int unsigned sh_primes[TABLE_DEPTH];
  longint unsigned sh_offsets[TABLE_DEPTH];

  in_beat_t pending_beats[$];
  out_beat_t expected_beats[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned segments_seen = 0;
  int unsigned full_loads = 0;
  int unsigned idle_cycles = 0;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch at beat %0d: %s got %0h want %0h", beats_out, what, got, want);
    error_count++;
  endtask

  function automatic out_beat_t make_beat(input int unsigned widx,
                                          input logic [63:0] bits,
                                          input bit st, input bit lst);
    out_beat_t b;
    b.word_index = widx[5:0];
    b.composite_bits = bits;
    b.segment_low = sh_base[BaseW-1:0];
    b.status = st;
    b.last = lst;
    return b;
  endfunction

  // work out the beats that one command produces and queue them
  task automatic predict_sieve(input in_beat_t beat);
    longint unsigned p, nb, sq, rem, first, off;
    logic [63:0] bitmap[WORDS];
    bit st;
    st = 1'b0;
    case (beat.cmd)
      CMD_LOAD: begin
        p = beat.base_prime;
        if (p >= 3 && p[0]) begin
          if (sh_count >= TABLE_DEPTH) begin
            st = 1'b1;
            full_loads++;
          end else begin
            nb = sh_first_done ? ((sh_base + 2 * SLOTS) & MASK40) : sh_base;
            sq = p * p;
            if (sq < nb) begin
              rem = nb % p;
              first = (rem == 0) ? nb : nb + (p - rem);
              if (!first[0]) first += p;
            end else begin
              first = sq;
            end
            sh_primes[sh_count] = p;
            sh_offsets[sh_count] = ((first - nb) / 2) & MASK40;
            sh_count++;
          end
        end
        expected_beats.push_back(make_beat(0, '0, st, 1'b1));
      end
      CMD_SEGMENT: begin
        if (sh_first_done) sh_base = (sh_base + 2 * SLOTS) & MASK40;
        else sh_first_done = 1'b1;
        foreach (bitmap[w]) bitmap[w] = '0;
        for (int i = 0; i < sh_count; i++) begin
          off = sh_offsets[i];
          while (off < SLOTS) begin
            bitmap[off >> 6][off & 63] = 1'b1;
            off += sh_primes[i];
          end
          sh_offsets[i] = (off - SLOTS) & MASK40;
        end
        for (int w = 0; w < WORDS; w++)
          expected_beats.push_back(make_beat(w, bitmap[w], 1'b0, w == WORDS - 1));
      end
      CMD_RESTART: begin
        sh_count = 0;
        sh_base = sh_start | 1;
        sh_first_done = 1'b0;
        expected_beats.push_back(make_beat(0, '0, 1'b0, 1'b1));
      end
      default: expected_beats.push_back(make_beat(0, '0, 1'b0, 1'b1));
    endcase
  endtask

  // driver: holds a beat until it is taken, and only then moves on
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_sieve(in_data);
        beats_in++;
        if (in_data.cmd == CMD_SEGMENT) segments_seen++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          in_data <= in_beat_t'($urandom);
        end
      end
    end
  end

  // receiver back-pressure, random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch("unpredicted beat, last", out_data.last, 0);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.word_index !== want.word_index)
          report_mismatch("word_index", out_data.word_index, want.word_index);
        if (out_data.composite_bits !== want.composite_bits)
          report_mismatch("composite_bits", out_data.composite_bits, want.composite_bits);
        if (out_data.segment_low !== want.segment_low)
          report_mismatch("segment_low", out_data.segment_low, want.segment_low);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
      beats_out++;
    end
  end

  // watchdog on cycles with no traffic in either direction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic in_beat_t mk(input logic [1:0] c, input int unsigned p);
    in_beat_t b;
    b.cmd = c;
    b.base_prime = p[PrimeW-1:0];
    return b;
  endfunction

  function automatic int unsigned rand_prime(input int unsigned hi);
    int unsigned n;
    bit ok;
    do begin
      n = $urandom_range(hi, 3) | 1;
      ok = 1'b1;
      for (int d = 3; d * d <= n; d += 2)
        if (n % d == 0) ok = 1'b0;
    end while (!ok);
    return n;
  endfunction

  // wait for the block to drain, then some slack
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_start(input longint unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[BaseW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_start = v & MASK40;
    sh_base = sh_start | 1;
    sh_first_done = 1'b0;
  endtask

  // a well-formed run: restart, load primes (mostly small), sieve a few segments
  task automatic queue_run(input int unsigned n_primes, input int unsigned n_segs);
    pending_beats.push_back(mk(CMD_RESTART, 0));
    for (int i = 0; i < n_primes; i++)
      pending_beats.push_back(mk(CMD_LOAD, rand_prime(($urandom_range(3) == 0) ?
                                                      1048575 : 2000)));
    for (int i = 0; i < n_segs; i++) pending_beats.push_back(mk(CMD_SEGMENT, $urandom));
  endtask

  initial begin
    sh_start = 3;
    sh_base = 3;
    sh_count = 0;
    sh_first_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset start, edge primes, invalid primes, unused command
    send_idle_pct = 34;
    recv_idle_pct = 76;
    pending_beats.push_back(mk(CMD_LOAD, 3));
    pending_beats.push_back(mk(CMD_LOAD, 5));
    pending_beats.push_back(mk(CMD_LOAD, 1048573));
    pending_beats.push_back(mk(CMD_LOAD, 0));
    pending_beats.push_back(mk(CMD_LOAD, 1));
    pending_beats.push_back(mk(CMD_LOAD, 2));
    pending_beats.push_back(mk(CMD_LOAD, 1048574));
    pending_beats.push_back(mk(CMD_LOAD, 1048575));
    pending_beats.push_back(mk(CMD_SPARE, 20'hFFFFF));
    pending_beats.push_back(mk(CMD_SEGMENT, 0));
    pending_beats.push_back(mk(CMD_SEGMENT, 20'hFFFFF));
    pending_beats.push_back(mk(CMD_LOAD, 7));
    pending_beats.push_back(mk(CMD_SEGMENT, 0));
    pending_beats.push_back(mk(CMD_RESTART, 20'hABCDE));
    pending_beats.push_back(mk(CMD_SEGMENT, 0));
    drain();

    // even start, keeps the stored table across the write
    write_start(64'd1000);
    pending_beats.push_back(mk(CMD_LOAD, 31));
    pending_beats.push_back(mk(CMD_SEGMENT, 0));
    drain();

    // largest start so the base wraps
    write_start(MASK40);
    queue_run(6, 3);
    drain();

    // start below three
    write_start(64'd0);
    queue_run(4, 2);
    drain();

    // random phases with varying starts and idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 34 : 0;
      write_start({$urandom, $urandom} & (($urandom_range(1)) ? MASK40 : 64'hFFFFF));
      for (int r = 0; r < 6; r++) begin
        queue_run($urandom_range(10, 1), $urandom_range(2, 1));
        if ($urandom_range(2) == 0)
          pending_beats.push_back(mk(2'($urandom), $urandom));
      end
      drain();
    end

    $display("ran %0d commands, %0d result beats, %0d segments, %0d loads into a full table",
             beats_in, beats_out, segments_seen, full_loads);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sos_pkg.sv
design/sos_datapath.sv
design/sos_ctrl.sv
design/segmented_odd_prime_sieve_unit.sv
tb/tb_top.sv
